### design/snic_pkg.sv
// ----------------------------------------------------------------------------
// snic_pkg
// Shared types, register indexes and width helpers for the shunting cell.
// ----------------------------------------------------------------------------
package snic_pkg;

  localparam int FracBits     = 12;
  localparam int CoefBits     = 15;
  localparam int GainLimBits  = 32;
  localparam int DriveLimBits = 48;
  localparam int MulLimBits   = 33;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_DECAY    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIX      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_EXC_GAIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EXC_FB   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INH_GAIN = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INH_FB   = 3'd5;

  typedef enum logic [2:0] {
    MUL_BE,
    MUL_BI,
    MUL_GE,
    MUL_GI,
    MUL_DY,
    MUL_ML,
    MUL_MH
  } mul_sel_t;

  typedef struct packed {
    logic signed [15:0] decay;
    logic [14:0]        mix_gain;
    logic signed [15:0] exc_gain;
    logic [14:0]        exc_feedback;
    logic signed [15:0] inh_gain;
    logic [14:0]        inh_feedback;
  } snic_cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_ge;
    logic     ld_gi;
    logic     ld_te;
    logic     ld_drive;
    logic     ld_acc;
    logic     add_acc;
    logic     finish;
    logic     fin_hi;
  } snic_cmd_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // gamma*2^12 - beta*yp plus rounding half
  function automatic int g24_w(input int w);
    return imax(w + 16, 28) + 2;
  endfunction

  function automatic int gain_w(input int w);
    return imin(g24_w(w) - FracBits, GainLimBits);
  endfunction

  function automatic int term_w(input int w);
    return gain_w(w) + w + 1 - FracBits;
  endfunction

  function automatic int drive_w(input int w);
    return imin(term_w(w) + 1, DriveLimBits);
  endfunction

  function automatic int mul_a_w(input int w);
    return imin(imax(gain_w(w), drive_w(w)), MulLimBits);
  endfunction

  function automatic int mul_b_w(input int w);
    return imax(w, 16);
  endfunction

  function automatic bit drive_split(input int w);
    return drive_w(w) > mul_a_w(w);
  endfunction

endpackage

### design/shunting_neuron_integrator_core.sv
// ----------------------------------------------------------------------------
// shunting_neuron_integrator_core
// One discrete-time shunting (Grossberg) cell in fixed point.
//
// Input channel (in_valid/in_ready) takes one beat per sample: exc_in, inh_in
// and first. Output channel (out_valid/out_ready) returns one y_out beat per
// input beat, in order. Configuration is a plain write port (cfg_we, cfg_idx,
// cfg_wdata): the user must write it only while the cell is idle; unchecked.
//
// A single shared multiplier runs the gain, drive and leak products in
// turn, one per cycle. The cell takes no new beat until the result of the
// last one has been registered at the output; for SAMPLE_WIDTH of 19 or
// more the drive product takes two multiplier passes.
//
// The output register parts the two sides: the next beat is accepted and
// computed while a result waits. If the receiver still stalls when the
// next result is ready, the cell holds it and takes no new beat.
//
// Reset clears the previous output to zero, loads the register defaults
// and leaves both channels empty with in_ready high.
// ----------------------------------------------------------------------------
module shunting_neuron_integrator_core #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [snic_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [snic_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] exc_in,
  input  logic signed [SAMPLE_WIDTH-1:0] inh_in,
  input  logic                          first,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] y_out
);
  import snic_pkg::*;

  snic_cfg_t cfg;
  snic_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay        <= '0;
      cfg.mix_gain     <= '0;
      cfg.exc_gain     <= 16'sd4096;
      cfg.exc_feedback <= '0;
      cfg.inh_gain     <= 16'sd4096;
      cfg.inh_feedback <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DECAY:    cfg.decay        <= cfg_wdata;
        REG_MIX:      cfg.mix_gain     <= cfg_wdata[14:0];
        REG_EXC_GAIN: cfg.exc_gain     <= cfg_wdata;
        REG_EXC_FB:   cfg.exc_feedback <= cfg_wdata[14:0];
        REG_INH_GAIN: cfg.inh_gain     <= cfg_wdata;
        REG_INH_FB:   cfg.inh_feedback <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  snic_ctrl #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  snic_dp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cmd   (cmd),
    .exc_in(exc_in),
    .inh_in(inh_in),
    .first (first),
    .y_out (y_out)
  );

endmodule

### design/snic_ctrl.sv
// ----------------------------------------------------------------------------
// snic_ctrl
// Sequencer for the shunting cell: steps the shared multiplier through the
// gain, drive and leak products and owns the channel handshakes.
// ----------------------------------------------------------------------------
module snic_ctrl #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output snic_pkg::snic_cmd_t cmd
);
  import snic_pkg::*;

  localparam bit Split = drive_split(SAMPLE_WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BE,
    ST_BI,
    ST_GE,
    ST_GI,
    ST_DY,
    ST_ML,
    ST_MH,
    ST_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_BE;
    unique case (state)
      ST_IDLE: cmd.load_in = in_valid && in_ready;
      ST_BE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BE;
      end
      ST_BI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BI;
        cmd.ld_ge   = 1'b1;
      end
      ST_GE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GE;
        cmd.ld_gi   = 1'b1;
      end
      ST_GI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GI;
        cmd.ld_te   = 1'b1;
      end
      ST_DY: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_DY;
        cmd.ld_drive = 1'b1;
      end
      ST_ML: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ML;
        cmd.ld_acc  = 1'b1;
      end
      ST_MH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MH;
        cmd.add_acc = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = out_free;
        cmd.fin_hi = Split;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_BE;
            in_ready <= 1'b0;
          end
        end
        ST_BE: state <= ST_BI;
        ST_BI: state <= ST_GE;
        ST_GE: state <= ST_GI;
        ST_GI: state <= ST_DY;
        ST_DY: state <= ST_ML;
        ST_ML: state <= Split ? ST_MH : ST_FIN;
        ST_MH: state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            in_ready  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/snic_dp.sv
// ----------------------------------------------------------------------------
// snic_dp
// Datapath for the shunting cell: one shared signed multiplier with a
// registered product, gain and drive rounding/saturation, leak accumulator,
// output register and previous-output state.
// ----------------------------------------------------------------------------
module snic_dp #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  snic_pkg::snic_cfg_t            cfg,
  input  snic_pkg::snic_cmd_t            cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] exc_in,
  input  logic signed [SAMPLE_WIDTH-1:0] inh_in,
  input  logic                           first,
  output logic signed [SAMPLE_WIDTH-1:0] y_out
);
  import snic_pkg::*;

  localparam int  W    = SAMPLE_WIDTH;
  localparam int  G24W = g24_w(W);
  localparam int  GRW  = G24W - FracBits;
  localparam int  GW   = gain_w(W);
  localparam int  TSW  = GW + W + 1;
  localparam int  TRW  = TSW - FracBits;
  localparam int  DRW  = TRW + 1;
  localparam int  DW   = drive_w(W);
  localparam int  MAW  = mul_a_w(W);
  localparam int  MBW  = mul_b_w(W);
  localparam int  PW   = MAW + MBW;
  localparam int  LW   = MAW - 1;
  localparam int  DXW  = imax(DW, MAW);
  localparam int  ACCW = imax(W, DW) + 18;
  localparam int  YRW  = ACCW - CoefBits;
  localparam bit  Split = drive_split(W);

  logic signed [W-1:0]    xe;
  logic signed [W-1:0]    xi;
  logic signed [W-1:0]    yp;
  logic signed [W-1:0]    prev;
  logic signed [GW-1:0]   ge;
  logic signed [GW-1:0]   gi;
  logic signed [TRW-1:0]  te;
  logic signed [DW-1:0]   drive;
  logic signed [PW-1:0]   p;
  logic signed [ACCW-1:0] acc;

  logic signed [MAW-1:0]  mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [DXW-1:0]  drive_x;

  logic signed [15:0]     gamma_sel;
  logic signed [G24W-1:0] g24;
  logic [GRW-1:0]         gr;
  logic                   g_ovf;
  logic signed [GW-1:0]   g_sat;

  logic signed [TSW-1:0]  t_sum;
  logic signed [TRW-1:0]  t_rnd;
  logic signed [DRW-1:0]  d_raw;
  logic                   d_ovf;
  logic signed [DW-1:0]   d_sat;

  logic signed [ACCW-1:0] acc_fin;
  logic [YRW-1:0]         yr;
  logic                   y_ovf;
  logic signed [W-1:0]    y_sat;

  assign drive_x = DXW'(drive);

  always_comb begin
    case (cmd.mul_sel)
      MUL_BE: begin
        mul_a = MAW'(yp);
        mul_b = MBW'($signed({1'b0, cfg.exc_feedback}));
      end
      MUL_BI: begin
        mul_a = MAW'(yp);
        mul_b = MBW'($signed({1'b0, cfg.inh_feedback}));
      end
      MUL_GE: begin
        mul_a = MAW'(ge);
        mul_b = MBW'(xe);
      end
      MUL_GI: begin
        mul_a = MAW'(gi);
        mul_b = MBW'(xi);
      end
      MUL_DY: begin
        mul_a = MAW'(yp);
        mul_b = MBW'($signed(cfg.decay));
      end
      MUL_ML: begin
        mul_a = Split ? MAW'($signed({1'b0, drive_x[LW-1:0]})) : MAW'(drive_x);
        mul_b = MBW'($signed({1'b0, cfg.mix_gain}));
      end
      MUL_MH: begin
        mul_a = MAW'(drive_x >>> LW);
        mul_b = MBW'($signed({1'b0, cfg.mix_gain}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // gain: round(gamma - beta*yp/2^12), saturate
  always_comb begin
    gamma_sel = cmd.ld_gi ? $signed(cfg.inh_gain) : $signed(cfg.exc_gain);
    g24   = G24W'($signed({gamma_sel, 1'b1, {(FracBits-1){1'b0}}})) - G24W'(p);
    gr    = g24[G24W-1:FracBits];
    g_ovf = (|gr[GRW-1:GW-1]) && !(&gr[GRW-1:GW-1]);
    g_sat = g_ovf ? {gr[GRW-1], {(GW-1){~gr[GRW-1]}}} : gr[GW-1:0];
  end

  // drive: round each product, subtract, saturate
  always_comb begin
    t_sum = TSW'(p) + TSW'(2 ** (FracBits - 1));
    t_rnd = t_sum[TSW-1:FracBits];
    d_raw = DRW'(te) - DRW'(t_rnd);
    d_ovf = (|d_raw[DRW-1:DW-1]) && !(&d_raw[DRW-1:DW-1]);
    d_sat = d_ovf ? {d_raw[DRW-1], {(DW-1){~d_raw[DRW-1]}}} : d_raw[DW-1:0];
  end

  // output: last partial product, drop coefficient fraction, saturate
  always_comb begin
    acc_fin = acc + (cmd.fin_hi ? (ACCW'(p) <<< LW) : ACCW'(p));
    yr      = acc_fin[ACCW-1:CoefBits];
    y_ovf   = (|yr[YRW-1:W-1]) && !(&yr[YRW-1:W-1]);
    y_sat   = y_ovf ? {yr[YRW-1], {(W-1){~yr[YRW-1]}}} : yr[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      xe <= exc_in;
      xi <= inh_in;
      yp <= first ? '0 : prev;
    end
    if (cmd.mul_en) begin
      p <= mul_a * mul_b;
    end
    if (cmd.ld_ge) begin
      ge <= g_sat;
    end
    if (cmd.ld_gi) begin
      gi <= g_sat;
    end
    if (cmd.ld_te) begin
      te <= t_rnd;
    end
    if (cmd.ld_drive) begin
      drive <= d_sat;
    end
    if (cmd.ld_acc) begin
      acc <= ACCW'(p) + ACCW'(2 ** (CoefBits - 1));
    end else if (cmd.add_acc) begin
      acc <= acc + ACCW'(p);
    end
    if (cmd.finish) begin
      y_out <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (cmd.finish) begin
      prev <= y_sat;
    end
  end

endmodule

### design/snic_checker.sv
// ----------------------------------------------------------------------------
// snic_checker
// Port-level checks for the shunting cell, bound to the top level.
// ----------------------------------------------------------------------------
module snic_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] y_out
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("channels not empty after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("beat accepted while another is in flight");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> !out_valid ##1 !out_valid)
    else $error("result shown too early");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(y_out)))
    else $error("stalled output beat dropped or changed");

endmodule

bind shunting_neuron_integrator_core snic_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_snic_checker (.*);
